// File: hdl/wcd_pkg.sv
// ----------------------------------------------------------------------------
// wcd_pkg - shared types and constants
// Field widths, register indexes and reset values for the windowed in-band
// count detector.
// ----------------------------------------------------------------------------
package wcd_pkg;

	localparam int TIME_W     = 20;
	localparam int TICK_W     = 18;
	localparam int TICK_SHIFT = 2;
	localparam int SMP_W      = 7;
	localparam int CNT_OUT_W  = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BAND_LOW     = 2'd0,
		CFG_BAND_HIGH    = 2'd1,
		CFG_START_TICK   = 2'd2,
		CFG_COUNT_NEEDED = 2'd3
	} cfg_reg_t;

	localparam logic [SMP_W-1:0]     BAND_LOW_RST     = 7'd17;
	localparam logic [SMP_W-1:0]     BAND_HIGH_RST    = 7'd27;
	localparam logic [TICK_W-1:0]    START_TICK_RST   = 18'd1000;
	localparam logic [CNT_OUT_W-1:0] COUNT_NEEDED_RST = 7'd50;
	localparam logic [CNT_OUT_W-1:0] BAND_COUNT_MAX   = 7'd127;

endpackage

// File: hdl/wcd_if.sv
// ----------------------------------------------------------------------------
// wcd_if - item and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface wcd_item_if;
	logic                           valid;
	logic                           ready;
	logic [wcd_pkg::TIME_W-1:0]     time_ms;
	logic [wcd_pkg::SMP_W-1:0]      sample;

	modport source (output valid, output time_ms, output sample, input ready);
	modport sink   (input valid, input time_ms, input sample, output ready);
endinterface

interface wcd_result_if;
	logic                           valid;
	logic                           ready;
	logic                           finished;
	logic [wcd_pkg::CNT_OUT_W-1:0]  band_count;

	modport source (output valid, output finished, output band_count, input ready);
	modport sink   (input valid, input finished, input band_count, output ready);
endinterface

// File: hdl/windowed_in_range_count_detector_top.sv
// ----------------------------------------------------------------------------
// windowed_in_range_count_detector_top - sliding window in-band count detector
// Path: an item passes the stage 1, 2 and 3 registers and the result register.
// Throughput: one item per cycle while the result channel is not stalled, set
// by the ring read-modify-write in the third stage with forwarding from the
// write of the item ahead. Reset: asynchronous; afterwards the ring is cleared
// slot by slot, during which no item is taken (configuration writes still apply).
// ----------------------------------------------------------------------------
module windowed_in_range_count_detector_top #(
	parameter int WINDOW = 100
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [wcd_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [wcd_pkg::CFG_DATA_W-1:0]       cfg_data,
	wcd_item_if.sink                             items,
	wcd_result_if.source                         results
);

	localparam int TW      = wcd_pkg::TICK_W;
	localparam int SW      = wcd_pkg::SMP_W;
	localparam int OW      = wcd_pkg::CNT_OUT_W;
	localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int SH      = TW + SLOT_W;
	localparam int PW      = TW + SH;
	localparam int RECIP   = (2 ** SH) / WINDOW;
	localparam int QW      = TW + 12;
	localparam int EXT_W   = CNT_W + OW;

	// configuration
	logic [SW-1:0]     band_low_q;
	logic [SW-1:0]     band_high_q;
	logic [TW-1:0]     start_tick_q;
	logic [OW-1:0]     count_needed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_low_q     <= wcd_pkg::BAND_LOW_RST;
			band_high_q    <= wcd_pkg::BAND_HIGH_RST;
			start_tick_q   <= wcd_pkg::START_TICK_RST;
			count_needed_q <= wcd_pkg::COUNT_NEEDED_RST;
		end else if (cfg_we) begin
			unique case (wcd_pkg::cfg_reg_t'(cfg_idx))
				wcd_pkg::CFG_BAND_LOW:     band_low_q     <= cfg_data[SW-1:0];
				wcd_pkg::CFG_BAND_HIGH:    band_high_q    <= cfg_data[SW-1:0];
				wcd_pkg::CFG_START_TICK:   start_tick_q   <= cfg_data[TW-1:0];
				wcd_pkg::CFG_COUNT_NEEDED: count_needed_q <= cfg_data[OW-1:0];
			endcase
		end
	end

	function automatic logic in_band(input logic [SW-1:0] v, input logic [SW-1:0] lo,
		input logic [SW-1:0] hi);
		return (v >= lo) && (v <= hi);
	endfunction

	// ring clear after reset
	logic              clr_q;
	logic [SLOT_W-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == SLOT_W'(WINDOW - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// pipeline advance
	logic out_valid_q;
	logic adv;

	assign adv         = !out_valid_q || results.ready;
	assign items.ready = adv && !clr_q;

	// stage 1: tick, window flags, reciprocal multiply
	logic          v_s1;
	logic [TW-1:0] tick_s1;
	logic [SW-1:0] smp_s1;
	logic [PW-1:0] prod_s1;
	logic          on_c;
	logic          full_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= items.valid && items.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tick_s1 <= items.time_ms[wcd_pkg::TIME_W-1:wcd_pkg::TICK_SHIFT];
			smp_s1  <= items.sample;
		end
	end

	assign prod_s1 = PW'(tick_s1) * PW'(RECIP);
	assign on_c    = tick_s1 >= start_tick_q;
	assign full_c  = {1'b0, tick_s1} >= ({1'b0, start_tick_q} + (TW + 1)'(WINDOW));

	// stage 2: remainder and correction, ring read
	logic          v_s2;
	logic [TW-1:0] tick_s2;
	logic [SW-1:0] smp_s2;
	logic [TW-1:0] quot_s2;
	logic          on_s2;
	logic          full_s2;
	logic [QW-1:0] qmul_c;
	logic [TW-1:0] rem_c;
	logic [SLOT_W-1:0] slot_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tick_s2 <= tick_s1;
			smp_s2  <= smp_s1;
			quot_s2 <= prod_s1[SH +: TW];
			on_s2   <= on_c;
			full_s2 <= full_c;
		end
	end

	assign qmul_c = QW'(quot_s2) * QW'(WINDOW);
	assign rem_c  = tick_s2 - qmul_c[TW-1:0];
	assign slot_c = (rem_c >= TW'(WINDOW)) ? SLOT_W'(rem_c - TW'(WINDOW)) : SLOT_W'(rem_c);

	// stage 3: count update and ring write
	logic              v_s3;
	logic [SW-1:0]     smp_s3;
	logic [SLOT_W-1:0] slot_s3;
	logic              on_s3;
	logic              full_s3;
	logic              byp_s3;
	logic [SW-1:0]     byp_data_s3;
	logic [SW-1:0]     rd_data;
	logic [SW-1:0]     old_smp;
	logic              wr_item;
	logic [CNT_W-1:0]  cnt_q;
	logic              drop;
	logic              add;
	logic [CNT_W-1:0]  cnt_mid;
	logic [CNT_W-1:0]  cnt_nxt;
	logic [EXT_W-1:0]  cnt_ext;
	logic              ring_we;
	logic [SLOT_W-1:0] ring_waddr;
	logic [SW-1:0]     ring_wdata;

	assign wr_item = v_s3 && on_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			smp_s3      <= smp_s2;
			slot_s3     <= slot_c;
			on_s3       <= on_s2;
			full_s3     <= full_s2;
			byp_s3      <= wr_item && (slot_s3 == slot_c);
			byp_data_s3 <= smp_s3;
		end
	end

	assign ring_we    = clr_q || (adv && wr_item);
	assign ring_waddr = clr_q ? clr_idx_q : slot_s3;
	assign ring_wdata = clr_q ? '0 : smp_s3;

	wcd_ring #(
		.DEPTH (WINDOW),
		.AW    (SLOT_W)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.re    (adv),
		.raddr (slot_c),
		.rdata (rd_data)
	);

	assign old_smp = byp_s3 ? byp_data_s3 : rd_data;
	assign drop    = on_s3 && full_s3 && in_band(old_smp, band_low_q, band_high_q)
		&& (cnt_q != '0);
	assign cnt_mid = cnt_q - CNT_W'(drop);
	assign add     = on_s3 && in_band(smp_s3, band_low_q, band_high_q)
		&& (cnt_mid < CNT_W'(WINDOW));
	assign cnt_nxt = cnt_mid + CNT_W'(add);
	assign cnt_ext = EXT_W'(cnt_nxt);

	// result register
	logic          finished_q;
	logic [OW-1:0] band_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (adv) begin
			out_valid_q <= v_s3;
			if (v_s3) begin
				cnt_q <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			finished_q   <= full_s3 && (cnt_ext >= EXT_W'(count_needed_q));
			band_count_q <= (cnt_ext > EXT_W'(wcd_pkg::BAND_COUNT_MAX)) ?
				wcd_pkg::BAND_COUNT_MAX : cnt_ext[OW-1:0];
		end
	end

	assign results.valid      = out_valid_q;
	assign results.finished   = finished_q;
	assign results.band_count = band_count_q;

endmodule

// File: hdl/wcd_ring.sv
// ----------------------------------------------------------------------------
// wcd_ring - sample ring storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module wcd_ring #(
	parameter int DEPTH = 100,
	parameter int AW    = 7
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [wcd_pkg::SMP_W-1:0]     wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [wcd_pkg::SMP_W-1:0]     rdata
);

	logic [wcd_pkg::SMP_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: tb/sv/wcd_band_monitor.sv
// ----------------------------------------------------------------------------
// wcd_band_monitor - result checker for the windowed in-band count detector
// Watches the configuration port and both channels, keeps its own copy of the
// sample ring and the in-band count, predicts one result per item transfer
// and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module wcd_band_monitor #(
	parameter int WINDOW = 100
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wcd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [wcd_pkg::CFG_DATA_W-1:0]  cfg_data,
	wcd_item_if                             items,
	wcd_result_if                           results,
	output int                              mismatches,
	output int                              outstanding
);

	typedef struct packed {
		logic                          finished;
		logic [wcd_pkg::CNT_OUT_W-1:0] band_count;
	} band_report_t;

	logic [wcd_pkg::SMP_W-1:0]     ring [WINDOW];
	int                            gray_count;
	logic [wcd_pkg::SMP_W-1:0]     band_lo;
	logic [wcd_pkg::SMP_W-1:0]     band_hi;
	logic [wcd_pkg::TICK_W-1:0]    start_tick;
	logic [wcd_pkg::CNT_OUT_W-1:0] count_needed;
	band_report_t                  expected_reports [$];

	function automatic logic in_gray(input logic [wcd_pkg::SMP_W-1:0] v);
		return v >= band_lo && v <= band_hi;
	endfunction

	function automatic band_report_t advance_window(
			input logic [wcd_pkg::TIME_W-1:0] t_ms,
			input logic [wcd_pkg::SMP_W-1:0] smp);
		logic [wcd_pkg::TICK_W-1:0] tick;
		int                         slot;
		logic                       full;
		band_report_t               r;
		tick = t_ms[wcd_pkg::TIME_W-1:wcd_pkg::TICK_SHIFT];
		full = int'(tick) >= int'(start_tick) + WINDOW;
		if (tick >= start_tick) begin
			slot = int'(tick) % WINDOW;
			if (full && in_gray(ring[slot]) && gray_count > 0)
				gray_count--;
			ring[slot] = smp;
			if (in_gray(smp) && gray_count < WINDOW)
				gray_count++;
		end
		r.finished   = full && gray_count >= int'(count_needed);
		r.band_count = (gray_count > int'(wcd_pkg::BAND_COUNT_MAX)) ?
				wcd_pkg::BAND_COUNT_MAX : gray_count[wcd_pkg::CNT_OUT_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			if (mismatches < 10)
				$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		band_report_t want;
		if (!arst_n) begin
			band_lo      = wcd_pkg::BAND_LOW_RST;
			band_hi      = wcd_pkg::BAND_HIGH_RST;
			start_tick   = wcd_pkg::START_TICK_RST;
			count_needed = wcd_pkg::COUNT_NEEDED_RST;
			for (int i = 0; i < WINDOW; i++)
				ring[i] = '0;
			gray_count = 0;
			expected_reports.delete();
			mismatches  = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (wcd_pkg::cfg_reg_t'(cfg_idx))
					wcd_pkg::CFG_BAND_LOW:
						band_lo      = cfg_data[wcd_pkg::SMP_W-1:0];
					wcd_pkg::CFG_BAND_HIGH:
						band_hi      = cfg_data[wcd_pkg::SMP_W-1:0];
					wcd_pkg::CFG_START_TICK:
						start_tick   = cfg_data[wcd_pkg::TICK_W-1:0];
					wcd_pkg::CFG_COUNT_NEEDED:
						count_needed = cfg_data[wcd_pkg::CNT_OUT_W-1:0];
					default: ;
				endcase
			end
			if (items.valid && items.ready)
				expected_reports.push_back(advance_window(items.time_ms, items.sample));
			if (results.valid && results.ready) begin
				if (expected_reports.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result transfer with no item outstanding", $realtime);
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					check_field("finished", int'(want.finished), int'(results.finished));
					check_field("band_count", int'(want.band_count),
						int'(results.band_count));
				end
			end
			outstanding <= expected_reports.size();
		end
	end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench top for the windowed in-band count detector
// Drives a short directed sequence and then runs of mostly rising timestamps with
// varying shares of in-band samples mixed with random noise, over several register
// settings and idle/stall mixes. Checking is done by wcd_band_monitor.
// ----------------------------------------------------------------------------
module tb;

	localparam int WINDOW      = 100;
	localparam int CYCLE_LIMIT = 300000;
	localparam int TIME_MAX    = (1 << wcd_pkg::TIME_W) - 1;
	localparam int TICK_MAX    = (1 << wcd_pkg::TICK_W) - 1;
	localparam int SMP_MAX     = 100;
	localparam int N_PHASES    = 5;
	localparam int IDLE_PCT    [N_PHASES] = '{0, 66, 0, 31, 0};
	localparam int STALL_PCT   [N_PHASES] = '{0, 0, 66, 31, 0};
	localparam int PHASE_ITEMS [N_PHASES] = '{170, 170, 170, 170, 40};

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [wcd_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [wcd_pkg::CFG_DATA_W-1:0] cfg_data;
	int                             idle_pct = 0;
	int                             stall_pct = 0;
	int                             cycles = 0;
	int                             mismatches;
	int                             outstanding;
	int                             cur_lo, cur_hi, cur_start;

	wcd_item_if   items_ch ();
	wcd_result_if results_ch ();

	windowed_in_range_count_detector_top #(.WINDOW(WINDOW)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.items    (items_ch),
		.results  (results_ch)
	);

	wcd_band_monitor #(.WINDOW(WINDOW)) band_mon (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.items       (items_ch),
		.results     (results_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		results_ch.ready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(input wcd_pkg::cfg_reg_t idx, input int value);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value[wcd_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			wcd_pkg::CFG_BAND_LOW:   cur_lo    = value;
			wcd_pkg::CFG_BAND_HIGH:  cur_hi    = value;
			wcd_pkg::CFG_START_TICK: cur_start = value;
			default: ;
		endcase
	endtask

	task automatic set_cfg(input int lo, input int hi, input int start, input int needed);
		write_reg(wcd_pkg::CFG_BAND_LOW, lo);
		write_reg(wcd_pkg::CFG_BAND_HIGH, hi);
		write_reg(wcd_pkg::CFG_START_TICK, start);
		write_reg(wcd_pkg::CFG_COUNT_NEEDED, needed);
	endtask

	task automatic send_item(input int t_ms, input int smp);
		while ($urandom_range(0, 99) < idle_pct) begin
			items_ch.valid <= 1'b0;
			@(posedge clk);
		end
		items_ch.valid   <= 1'b1;
		items_ch.time_ms <= t_ms[wcd_pkg::TIME_W-1:0];
		items_ch.sample  <= smp[wcd_pkg::SMP_W-1:0];
		do @(posedge clk); while (items_ch.ready !== 1'b1);
	endtask

	task automatic drain_results;
		items_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (5) @(posedge clk);
	endtask

	function automatic int pick_sample(input int in_pct);
		if ($urandom_range(0, 99) < in_pct && cur_lo <= cur_hi)
			return $urandom_range(cur_lo, cur_hi);
		return $urandom_range(0, SMP_MAX);
	endfunction

	// runs of mostly rising timestamps around the start tick, with some noise
	task automatic run_phase(input int n);
		int sent, base, step, len, pct, t, i;
		sent = 0;
		while (sent < n) begin
			base = cur_start + int'($urandom_range(0, 300)) - 40;
			if (base < 0)
				base = 0;
			step = ($urandom_range(0, 9) < 7) ? 4 : int'($urandom_range(0, 12));
			len  = $urandom_range(20, 130);
			case ($urandom_range(0, 3))
				0:       pct = 100;
				1:       pct = 85;
				2:       pct = 50;
				default: pct = 10;
			endcase
			for (i = 0; i < len && sent < n; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item($urandom_range(0, TIME_MAX), $urandom_range(0, SMP_MAX));
				end else begin
					t = base * 4 + i * step + int'($urandom_range(0, 3));
					if (t > TIME_MAX)
						t = TIME_MAX - int'($urandom_range(0, 7));
					send_item(t, pick_sample(pct));
				end
				sent++;
				if (sent == n / 2)
					drain_results;
			end
		end
	endtask

	initial begin
		int lo;
		items_ch.valid   <= 1'b0;
		items_ch.time_ms <= '0;
		items_ch.sample  <= '0;
		cfg_we           <= 1'b0;
		cfg_idx          <= wcd_pkg::CFG_BAND_LOW;
		cfg_data         <= '0;
		arst_n           <= 1'b0;
		cur_lo    = int'(wcd_pkg::BAND_LOW_RST);
		cur_hi    = int'(wcd_pkg::BAND_HIGH_RST);
		cur_start = int'(wcd_pkg::START_TICK_RST);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: before start, top of time range, band edges, removal
		send_item(0, 0);
		send_item(TIME_MAX, SMP_MAX);
		send_item(4000, 17);
		send_item(4004, 27);
		send_item(4008, 16);
		send_item(4012, 28);
		send_item(3999, 20);
		send_item(4400, 22);
		send_item(4404, 0);
		send_item(4800, 0);
		drain_results;
		// empty band
		write_reg(wcd_pkg::CFG_BAND_LOW, 30);
		write_reg(wcd_pkg::CFG_BAND_HIGH, 10);
		send_item(4408, 20);
		send_item(4412, 30);
		drain_results;
		// removal with the count already at zero, finished with zero needed
		set_cfg(0, 0, 0, 0);
		send_item(600, 50);
		send_item(0, 0);
		drain_results;

		for (int p = 0; p < N_PHASES; p++) begin
			idle_pct  = IDLE_PCT[p];
			stall_pct <= STALL_PCT[p];
			case (p)
				0: set_cfg(int'(wcd_pkg::BAND_LOW_RST), int'(wcd_pkg::BAND_HIGH_RST),
						int'(wcd_pkg::START_TICK_RST), int'(wcd_pkg::COUNT_NEEDED_RST));
				1: set_cfg(0, SMP_MAX, 0, WINDOW);
				2: begin
					lo = $urandom_range(0, 60);
					set_cfg(lo, lo + int'($urandom_range(0, 40)), $urandom_range(0, 3000),
							$urandom_range(0, SMP_MAX));
				end
				3: set_cfg($urandom_range(0, SMP_MAX), $urandom_range(0, SMP_MAX),
						$urandom_range(0, 20000), 0);
				default: set_cfg(0, SMP_MAX, TICK_MAX, 1);
			endcase
			run_phase(PHASE_ITEMS[p]);
			drain_results;
		end

		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
